// ===== sv/qrrd_pkg.sv =====
`default_nettype none

package qrrd_pkg;

    // fixed field widths
    localparam int POINT_W     = 32;
    localparam int GRID_W      = 16;
    localparam int TCNT_W      = 8;
    localparam int GRAIN_OUT_W = 16;
    localparam int QUAD_W      = 2;
    localparam int THREAD_W    = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // scaling and sizing constants
    localparam int MAX_THREADS = 128;
    localparam int FRAC_BITS   = 16;
    localparam int GRAIN_BITS  = 16;

    // derived widths
    localparam int SUM_W  = POINT_W + 1;
    localparam int LIM_W  = SUM_W + 1;
    localparam int TCL_W  = $clog2(MAX_THREADS + 1);

    // centre sums hold twice the centre; two in that scale is four
    localparam logic [SUM_W-1:0] SUM_TWO  = SUM_W'(4) << FRAC_BITS;
    localparam logic [SUM_W-1:0] SUM_UNIT = SUM_W'(1) << FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PARALLEL = 2'd0,
        CFG_THREADS  = 2'd1,
        CFG_GRID     = 2'd2
    } t_cfg_idx;

    typedef enum logic [QUAD_W-1:0] {
        QD_LOWER_LEFT  = 2'd0,
        QD_LOWER_RIGHT = 2'd1,
        QD_UPPER_LEFT  = 2'd2,
        QD_OTHER       = 2'd3
    } t_quad;

    // grid side in fixed point, zero counts as one
    function automatic logic [POINT_W-1:0] f_grid_fix(input logic [GRID_W-1:0] grid);
        logic [GRID_W-1:0] g;
        g = (grid == '0) ? GRID_W'(1) : grid;
        return POINT_W'({g, {FRAC_BITS{1'b0}}});
    endfunction

endpackage

`default_nettype wire

// ===== sv/qrrd_point_if.sv =====
`default_nettype none

interface qrrd_point_if;
    logic                         valid;
    logic                         ready;
    logic [qrrd_pkg::POINT_W-1:0] point_x;
    logic [qrrd_pkg::POINT_W-1:0] point_y;
    logic                         last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/qrrd_result_if.sv =====
`default_nettype none

interface qrrd_result_if;
    logic                             valid;
    logic                             ready;
    logic [qrrd_pkg::GRAIN_OUT_W-1:0] grain_number;
    logic [qrrd_pkg::QUAD_W-1:0]      quadrant;
    logic [qrrd_pkg::THREAD_W-1:0]    thread_number;

    modport source (output valid, output grain_number, output quadrant,
                    output thread_number, input ready);
    modport sink   (input valid, input grain_number, input quadrant,
                    input thread_number, output ready);
endinterface

`default_nettype wire

// ===== sv/quadrant_round_robin_dispatcher.sv =====
// a last point's result passes through the input register and then the result register
// throughput: one point per cycle; the box update and the per-quadrant rotate
//   index update happen in the same cycle, so back-to-back points and grains never stall
//   while the result register is free or is being emptied
// reset: synchronous, active low; restores register defaults, reloads the box,
//   sets the grain number to one and clears all rotate indexes
`default_nettype none

module quadrant_round_robin_dispatcher (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    qrrd_point_if.sink                        i_point,
    qrrd_result_if.source                     o_result,
    input  wire                               i_cfg_we,
    input  wire [qrrd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [qrrd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // configuration registers
    logic                              r_par_en;
    logic [qrrd_pkg::TCNT_W-1:0]       r_thread_cnt;
    logic [qrrd_pkg::GRID_W-1:0]       r_grid;

    // input register
    logic                              r_in_valid;
    logic [qrrd_pkg::POINT_W-1:0]      r_in_x;
    logic [qrrd_pkg::POINT_W-1:0]      r_in_y;
    logic                              r_in_last;

    // grain state
    logic [qrrd_pkg::POINT_W-1:0]      r_min_x, r_max_x, r_min_y, r_max_y;
    logic [qrrd_pkg::GRAIN_BITS-1:0]   r_grain_cnt;
    logic [qrrd_pkg::TCL_W-1:0]        r_rot [4];
    logic                              r_grain_open;

    // result register
    logic                              r_out_valid;
    logic [qrrd_pkg::GRAIN_OUT_W-1:0]  r_out_grain;
    qrrd_pkg::t_quad                   r_out_quad;
    logic [qrrd_pkg::THREAD_W-1:0]     r_out_thread;

    logic                              w_adv;
    logic                              w_in_ready;
    logic                              w_cfg_grid;

    logic [qrrd_pkg::POINT_W-1:0]      n_min_x, n_max_x, n_min_y, n_max_y;
    logic [qrrd_pkg::SUM_W-1:0]        w_sx, w_sy;
    logic                              w_grid;
    logic [qrrd_pkg::SUM_W-1:0]        w_lim1;
    logic [qrrd_pkg::LIM_W-1:0]        w_lim3;
    logic                              w_px0, w_px1, w_py0, w_py1;
    qrrd_pkg::t_quad                   w_quad;

    logic [qrrd_pkg::TCL_W-1:0]        w_tcl, w_base, w_offset, w_n, w_ri, w_ri_next;
    logic [qrrd_pkg::TCL_W-1:0]        w_thread;
    logic [1:0]                        w_rest;
    logic                              w_par;

    // handshake: a non-last point always moves on, a last point needs a free result slot
    assign w_adv      = r_in_valid && (!r_in_last || !r_out_valid || o_result.ready);
    assign w_in_ready = !r_in_valid || w_adv;
    assign i_point.ready = w_in_ready;
    assign w_cfg_grid = i_cfg_we && (i_cfg_idx == qrrd_pkg::CFG_GRID);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par_en     <= 1'b0;
            r_thread_cnt <= qrrd_pkg::TCNT_W'(1);
            r_grid       <= qrrd_pkg::GRID_W'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qrrd_pkg::CFG_PARALLEL: r_par_en     <= i_cfg_data[0];
                qrrd_pkg::CFG_THREADS:  r_thread_cnt <= i_cfg_data[qrrd_pkg::TCNT_W-1:0];
                qrrd_pkg::CFG_GRID:     r_grid       <= i_cfg_data[qrrd_pkg::GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_point.valid;
        end
        if (w_in_ready && i_point.valid) begin
            r_in_x    <= i_point.point_x;
            r_in_y    <= i_point.point_y;
            r_in_last <= i_point.last_point;
        end
    end

    // bounding box including the current point
    assign n_min_x = (r_in_x < r_min_x) ? r_in_x : r_min_x;
    assign n_max_x = (r_in_x > r_max_x) ? r_in_x : r_max_x;
    assign n_min_y = (r_in_y < r_min_y) ? r_in_y : r_min_y;
    assign n_max_y = (r_in_y > r_max_y) ? r_in_y : r_max_y;

    // centre classification by compares: position 0 below one step, 1 below three
    assign w_sx   = qrrd_pkg::SUM_W'(n_min_x) + qrrd_pkg::SUM_W'(n_max_x);
    assign w_sy   = qrrd_pkg::SUM_W'(n_min_y) + qrrd_pkg::SUM_W'(n_max_y);
    assign w_grid = w_sx > qrrd_pkg::SUM_TWO;
    assign w_lim1 = w_grid ? qrrd_pkg::SUM_W'(qrrd_pkg::f_grid_fix(r_grid))
                           : qrrd_pkg::SUM_UNIT;
    assign w_lim3 = qrrd_pkg::LIM_W'(w_lim1) + {w_lim1, 1'b0};
    assign w_px0  = w_sx < w_lim1;
    assign w_px1  = !w_px0 && (qrrd_pkg::LIM_W'(w_sx) < w_lim3);
    assign w_py0  = w_sy < w_lim1;
    assign w_py1  = !w_py0 && (qrrd_pkg::LIM_W'(w_sy) < w_lim3);

    always_comb begin
        priority if (w_px0 && w_py0) w_quad = qrrd_pkg::QD_LOWER_LEFT;
        else if (w_px1 && w_py0)     w_quad = qrrd_pkg::QD_LOWER_RIGHT;
        else if (w_px0 && w_py1)     w_quad = qrrd_pkg::QD_UPPER_LEFT;
        else                         w_quad = qrrd_pkg::QD_OTHER;
    end

    // thread split: quarter of the clamped count, lower-numbered quadrants take the remainder
    assign w_tcl  = (int'(r_thread_cnt) > qrrd_pkg::MAX_THREADS)
                  ? qrrd_pkg::TCL_W'(qrrd_pkg::MAX_THREADS)
                  : qrrd_pkg::TCL_W'(r_thread_cnt);
    assign w_base = w_tcl >> 2;
    assign w_rest = w_tcl[1:0];
    assign w_par  = r_par_en && (w_tcl >= qrrd_pkg::TCL_W'(4));

    always_comb begin
        unique case (w_quad)
            qrrd_pkg::QD_LOWER_LEFT:  w_offset = '0;
            qrrd_pkg::QD_LOWER_RIGHT: w_offset = w_base
                                              + qrrd_pkg::TCL_W'(w_rest >= 2'd1);
            qrrd_pkg::QD_UPPER_LEFT:  w_offset = (w_base << 1)
                                              + qrrd_pkg::TCL_W'((w_rest > 2'd2) ? 2'd2
                                                                                 : w_rest);
            default:                  w_offset = w_base + (w_base << 1)
                                              + qrrd_pkg::TCL_W'(w_rest);
        endcase
    end

    assign w_n       = w_base + qrrd_pkg::TCL_W'(w_quad < w_rest);
    // an index left over from a larger thread count restarts at zero
    assign w_ri      = (r_rot[w_quad] >= w_n) ? '0 : r_rot[w_quad];
    assign w_ri_next = (w_ri + qrrd_pkg::TCL_W'(1) >= w_n) ? '0 : w_ri + qrrd_pkg::TCL_W'(1);
    assign w_thread  = w_par ? (w_offset + w_ri) : '0;

    // grain state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x      <= qrrd_pkg::f_grid_fix(qrrd_pkg::GRID_W'(256));
            r_min_y      <= qrrd_pkg::f_grid_fix(qrrd_pkg::GRID_W'(256));
            r_max_x      <= '0;
            r_max_y      <= '0;
            r_grain_cnt  <= qrrd_pkg::GRAIN_BITS'(1);
            r_grain_open <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_rot[k] <= '0;
            end
        end else if (w_adv) begin
            if (r_in_last) begin
                r_min_x      <= qrrd_pkg::f_grid_fix(r_grid);
                r_min_y      <= qrrd_pkg::f_grid_fix(r_grid);
                r_max_x      <= '0;
                r_max_y      <= '0;
                r_grain_open <= 1'b0;
                if (r_grain_cnt != '1) begin
                    r_grain_cnt <= r_grain_cnt + qrrd_pkg::GRAIN_BITS'(1);
                end
                if (w_par) begin
                    r_rot[w_quad] <= w_ri_next;
                end
            end else begin
                r_min_x      <= n_min_x;
                r_min_y      <= n_min_y;
                r_max_x      <= n_max_x;
                r_max_y      <= n_max_y;
                r_grain_open <= 1'b1;
            end
        end else if (w_cfg_grid && !r_grain_open) begin
            // new grid before the first point of a grain reloads the box
            r_min_x <= qrrd_pkg::f_grid_fix(i_cfg_data[qrrd_pkg::GRID_W-1:0]);
            r_min_y <= qrrd_pkg::f_grid_fix(i_cfg_data[qrrd_pkg::GRID_W-1:0]);
            r_max_x <= '0;
            r_max_y <= '0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv && r_in_last) begin
            r_out_grain  <= qrrd_pkg::GRAIN_OUT_W'(r_grain_cnt);
            r_out_quad   <= w_quad;
            r_out_thread <= qrrd_pkg::THREAD_W'(w_thread);
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.grain_number  = r_out_grain;
    assign o_result.quadrant      = r_out_quad;
    assign o_result.thread_number = r_out_thread;

`ifndef ASSERT_OFF
    // a nonzero thread only goes out in parallel mode with at least four threads
    a_seq_thread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_thread != '0)) |-> w_par)
        else $error("nonzero thread in sequential mode");

    // grain numbering never wraps to zero
    a_grain_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grain_cnt != '0)
        else $error("grain counter reached zero");

    // a finished grain leaves an empty box behind
    a_box_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> (r_max_x == '0 && r_max_y == '0 && !r_grain_open))
        else $error("box not reloaded after last point");

    // a last point that moves on always produces a visible result
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> r_out_valid)
        else $error("result lost");
`endif

endmodule

`default_nettype wire

// ===== bench/qrrd_dispatch_tracker.sv =====
`timescale 1ns / 100ps

module qrrd_dispatch_tracker
    import qrrd_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    qrrd_point_if                 i_point,
    qrrd_result_if                i_result,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [GRAIN_OUT_W-1:0] grain;
        t_quad                  quad;
        logic [THREAD_W-1:0]    thread;
    } t_grain_dispatch;

    // dispatches predicted but not yet seen on the result channel
    t_grain_dispatch dispatch_q[$];

    // register copies
    logic              par_en;
    logic [TCNT_W-1:0] thr_cnt;
    logic [GRID_W-1:0] grid_pts;

    // bounding box and dispatch state
    logic [POINT_W-1:0]     box_min_x, box_max_x, box_min_y, box_max_y;
    logic [GRAIN_OUT_W-1:0] grain_no;
    int                     rot_idx [4];
    bit                     grain_open;

    // grid side in fixed point, a zero grid acts as one
    function automatic logic [63:0] grid_unit();
        logic [63:0] side;
        side = (grid_pts == '0) ? 64'd1 : 64'(grid_pts);
        return side << FRAC_BITS;
    endfunction

    // empty box seeded from the grid side
    task automatic reload_box();
        box_min_x = POINT_W'(grid_unit());
        box_min_y = box_min_x;
        box_max_x = '0;
        box_max_y = '0;
    endtask

    // round a doubled centre to a position, unit or grid scale
    function automatic logic [63:0] centre_pos(input logic [63:0] sum, input bit in_grid);
        logic [63:0] n;
        n = grid_unit();
        if (in_grid)
            return (sum + n) / (n << 1);
        return (sum + 64'(SUM_UNIT)) >> (FRAC_BITS + 1);
    endfunction

    // grow the box; on the last point classify and pick a thread
    task automatic predict_point(input logic [POINT_W-1:0] x, input logic [POINT_W-1:0] y,
                                 input logic last);
        logic [63:0]         sx, sy, px, py;
        bit                  in_grid;
        t_quad               q;
        int                  t, base, rest, offset, span;
        logic [THREAD_W-1:0] thr;
        t_grain_dispatch     pred_d;

        if (x < box_min_x) box_min_x = x;
        if (x > box_max_x) box_max_x = x;
        if (y < box_min_y) box_min_y = y;
        if (y > box_max_y) box_max_y = y;
        grain_open = 1'b1;
        if (!last)
            return;

        sx = 64'(box_min_x) + 64'(box_max_x);
        sy = 64'(box_min_y) + 64'(box_max_y);
        in_grid = sx > 64'(SUM_TWO);
        px = centre_pos(sx, in_grid);
        py = centre_pos(sy, in_grid);
        if (px == 0 && py == 0)      q = QD_LOWER_LEFT;
        else if (px == 1 && py == 0) q = QD_LOWER_RIGHT;
        else if (px == 0 && py == 1) q = QD_UPPER_LEFT;
        else                         q = QD_OTHER;

        // split threads over quadrants, lower-numbered quadrants take the remainder
        thr = '0;
        t = (int'(thr_cnt) > MAX_THREADS) ? MAX_THREADS : int'(thr_cnt);
        if (par_en && t >= 4) begin
            base = t / 4;
            rest = t % 4;
            offset = 0;
            for (int k = 0; k < int'(q); k++)
                offset += base + ((k < rest) ? 1 : 0);
            span = base + ((int'(q) < rest) ? 1 : 0);
            if (rot_idx[q] >= span)
                rot_idx[q] = 0;
            thr = THREAD_W'(offset + rot_idx[q]);
            rot_idx[q] = (rot_idx[q] + 1 >= span) ? 0 : rot_idx[q] + 1;
        end

        pred_d = '{grain: grain_no, quad: q, thread: thr};
        dispatch_q = {dispatch_q, pred_d};
        if (grain_no != {GRAIN_OUT_W{1'b1}})
            grain_no = grain_no + GRAIN_OUT_W'(1);
        reload_box();
        grain_open = 1'b0;
    endtask

    // watch the channels and the register port
    always @(posedge i_clk) begin
        t_grain_dispatch exp_d;
        if (!i_rst_n) begin
            par_en = 1'b0;
            thr_cnt = TCNT_W'(1);
            grid_pts = GRID_W'(256);
            reload_box();
            grain_no = GRAIN_OUT_W'(1);
            rot_idx = '{default: 0};
            grain_open = 1'b0;
            dispatch_q.delete();
        end else begin
            // compare a finished grain against the oldest prediction
            if (i_result.valid && i_result.ready) begin
                if (dispatch_q.size() == 0) begin
                    $error("grain_number %0d dispatched with no grain pending",
                           i_result.grain_number);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_d = dispatch_q.pop_front();
                    if (i_result.grain_number !== exp_d.grain ||
                        i_result.quadrant !== exp_d.quad ||
                        i_result.thread_number !== exp_d.thread)
                        o_fail_count <= o_fail_count + 1;
                    if (i_result.grain_number !== exp_d.grain)
                        $error("grain_number mismatch: expected %0d, actual %0d",
                               exp_d.grain, i_result.grain_number);
                    if (i_result.quadrant !== exp_d.quad)
                        $error("quadrant mismatch: expected %0d, actual %0d",
                               exp_d.quad, i_result.quadrant);
                    if (i_result.thread_number !== exp_d.thread)
                        $error("thread_number mismatch: expected %0d, actual %0d",
                               exp_d.thread, i_result.thread_number);
                end
            end

            // register writes; unmapped indexes fall through
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PARALLEL: par_en = i_cfg_data[0];
                    CFG_THREADS:  thr_cnt = i_cfg_data[TCNT_W-1:0];
                    CFG_GRID: begin
                        grid_pts = i_cfg_data[GRID_W-1:0];
                        if (!grain_open)
                            reload_box();
                    end
                    default: ;
                endcase
            end

            if (i_point.valid && i_point.ready)
                predict_point(i_point.point_x, i_point.point_y, i_point.last_point);
        end
        o_pending <= dispatch_q.size();
    end

endmodule

// ===== bench/quadrant_round_robin_dispatcher_tb.sv =====
`timescale 1ns / 100ps

module quadrant_round_robin_dispatcher_tb;
    import qrrd_pkg::*;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // cycles to let the pipeline empty once nothing is pending
    localparam int SETTLE_CYCLES = 6;
    localparam int RUN_GRAINS = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  rx_ready = 1'b0;
    bit                    send_idle = 1'b1;
    bit                    recv_idle = 1'b1;
    logic [GRID_W-1:0]     cur_grid = GRID_W'(256);
    int                    fail_count;
    int                    pending;

    qrrd_point_if  pt ();
    qrrd_result_if res ();

    assign res.ready = rx_ready;

    quadrant_round_robin_dispatcher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_point    (pt),
        .o_result   (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    qrrd_dispatch_tracker u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_point      (pt),
        .i_result     (res),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            rx_ready <= 1'b0;
        else
            rx_ready <= recv_idle ? ($urandom_range(0, 99) >= 15) : 1'b1;
    end

    // run limit
    initial begin
        #24_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // one point transaction, with optional gaps before it
    task automatic send_point(input logic [POINT_W-1:0] x, input logic [POINT_W-1:0] y,
                              input logic last);
        while (send_idle && $urandom_range(0, 99) < 15) begin
            pt.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt.valid      <= 1'b1;
        pt.point_x    <= x;
        pt.point_y    <= y;
        pt.last_point <= last;
        do @(posedge i_clk); while (!pt.ready);
    endtask

    // stop sending and wait for every dispatch to come out
    task automatic settle();
        pt.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == CFG_GRID)
            cur_grid = data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // coordinates near unit scale, grid scale, anywhere, or at the edges
    function automatic logic [POINT_W-1:0] pick_coord(input int family);
        logic [POINT_W-1:0] side;
        side = (cur_grid == '0) ? 32'h0001_0000 : {cur_grid, 16'h0000};
        case (family)
            0:       return $urandom_range(0, 32'h0002_8000);
            1:       return $urandom_range(0, side);
            2:       return $urandom();
            default: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return side;
                    default: return 32'h0000_8000;
                endcase
            end
        endcase
    endfunction

    // one contour of n points, the last one marked
    task automatic send_grain(input int n_pts);
        int family;
        family = $urandom_range(0, 3);
        for (int k = 0; k < n_pts; k++)
            send_point(pick_coord(family), pick_coord(family), k == n_pts - 1);
    endtask

    initial begin
        int thread_picks [12];
        int grid_picks [7];
        int sent;
        int n_pts;

        thread_picks = '{0, 1, 3, 4, 5, 6, 7, 9, 127, 128, 129, 255};
        grid_picks   = '{0, 1, 2, 3, 256, 1000, 65535};
        pt.valid      <= 1'b0;
        pt.point_x    <= '0;
        pt.point_y    <= '0;
        pt.last_point <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: sequential, grid 256
        send_point('0, '0, 1'b1);
        send_point('1, '1, 1'b1);
        send_point(32'h0001_0000, '0, 1'b1);
        send_point('0, 32'h0001_0000, 1'b1);
        // centre exactly two stays in unit scale, just above goes to grid scale
        send_point(32'h0002_0000, '0, 1'b1);
        send_point(32'h0002_0001, '0, 1'b1);
        // half rounds up
        send_point(32'h0000_8000, 32'h0000_8000, 1'b1);
        send_point(32'h0000_1000, 32'h0000_2000, 1'b0);
        send_point(32'h0000_3000, 32'h0000_0100, 1'b0);
        send_point(32'h0000_0800, 32'h0000_4000, 1'b1);

        // grid change in the middle of a grain keeps the box
        send_point(32'h0003_0000, '0, 1'b0);
        settle();
        write_reg(CFG_GRID, 16'd1);
        send_point(32'h0003_0000, '0, 1'b1);
        // zero grid before the first point reloads the box
        settle();
        write_reg(CFG_GRID, 16'd0);
        send_point(32'h0003_0000, 32'h0003_0000, 1'b1);

        // uneven split over quadrants
        settle();
        write_reg(CFG_PARALLEL, 16'd1);
        write_reg(CFG_THREADS, 16'd7);
        repeat (3) send_point('0, '0, 1'b1);
        repeat (2) send_point('1, '1, 1'b1);
        // too many threads clamps, then a drop restarts the rotation
        settle();
        write_reg(CFG_THREADS, 16'd200);
        repeat (3) send_point('1, '1, 1'b1);
        settle();
        write_reg(CFG_THREADS, 16'd8);
        send_point('1, '1, 1'b1);
        // below four threads stays sequential; unmapped index is ignored
        settle();
        write_reg(CFG_THREADS, 16'd3);
        write_reg(CFG_SPARE, 16'hFFFF);
        send_point(32'h0001_0000, '0, 1'b1);

        // random phases with fresh settings, some leaving a grain open
        for (int ph = 0; ph < 5; ph++) begin
            settle();
            write_reg(CFG_PARALLEL, (ph == 0) ? 16'd0 : 16'($urandom_range(0, 3) != 0));
            write_reg(CFG_THREADS, ($urandom_range(0, 2) == 0) ?
                      16'($urandom_range(0, 255)) : 16'(thread_picks[$urandom_range(0, 11)]));
            write_reg(CFG_GRID, (ph == 4) ? 16'($urandom()) :
                      16'(grid_picks[$urandom_range(0, 6)]));
            send_idle = (ph != 2);
            recv_idle = (ph != 3);
            sent = 0;
            while (sent < 85) begin
                n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
                send_grain(n_pts);
                sent += n_pts;
            end
            if (ph % 2 == 1)
                send_point(pick_coord(2), pick_coord(2), 1'b0);
        end

        // long run without gaps on either side
        settle();
        write_reg(CFG_PARALLEL, 16'd1);
        write_reg(CFG_THREADS, 16'd128);
        write_reg(CFG_GRID, 16'd65535);
        send_idle = 1'b0;
        recv_idle = 1'b0;
        for (int g = 0; g < RUN_GRAINS; g++)
            send_point($urandom(), $urandom(), 1'b1);
        settle();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== quadrant_round_robin_dispatcher.f =====
sv/qrrd_pkg.sv
sv/qrrd_point_if.sv
sv/qrrd_result_if.sv
sv/quadrant_round_robin_dispatcher.sv
bench/qrrd_dispatch_tracker.sv
bench/quadrant_round_robin_dispatcher_tb.sv
